### rtl/core/fad_pkg.sv
// Shared types and codes for the bounded array deque.
// No dependencies; imported by fixed_array_deque_shift and fad_index.
package fad_pkg;

    // operation carried by an input word
    typedef enum logic [1:0] {
        KIND_PUSH_BACK  = 2'd0,
        KIND_PUSH_FRONT = 2'd1,
        KIND_POP_BACK   = 2'd2,
        KIND_POP_FRONT  = 2'd3
    } fad_kind_t;

    // status reported with every listed entry
    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } fad_status_t;

    // top-level sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_LIST
    } fad_state_t;

    // write request from the index unit to the entry memory
    typedef struct packed {
        logic        en;
        fad_status_t status;
    } fad_upd_t;

    localparam int unsigned DATA_W = 32;

endpackage

### rtl/core/fixed_array_deque_shift.sv
// Bounded deque of signed 32-bit words kept in a circular RAM (head + count).
// Each accepted input word passes through ST_PREP, where the first RAM read is set up, before ST_LIST.
// A new operation is taken only once the whole listing of the last one has gone out; the listing reads the
// entry RAM one word per cycle while the receiver does not stall, through its single read port.
// Reset (async, active low) empties the store; RAM contents are not cleared.
module fixed_array_deque_shift
    import fad_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [31:0] value
    input  logic [1:0]        s_tuser,   // [1:0] kind
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [31:0] entry_value
    output logic [2:0]        m_tuser,   // [1:0] status, [2] entry_valid
    output logic              m_tlast
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [AW:0] CAP_EXT = (AW+1)'(CAPACITY);

    fad_state_t    state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    fad_status_t   status_reg, status_next;

    logic              in_fire, out_fire;
    fad_upd_t          upd;
    logic [AW-1:0]     wr_addr, head, rd_addr;
    logic [CW-1:0]     count;
    logic [AW:0]       rd_sum;
    logic [DATA_W-1:0] rd_data;
    logic              is_last, non_empty;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    // pointer and count unit
    fad_index #(
        .CAPACITY (CAPACITY)
    ) u_index (
        .clk     (clk),
        .rst_n   (rst_n),
        .apply   (in_fire),
        .kind    (fad_kind_t'(s_tuser)),
        .upd     (upd),
        .wr_addr (wr_addr),
        .head    (head),
        .count   (count)
    );

    // entry store
    fad_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (in_fire && upd.en),
        .waddr (wr_addr),
        .wdata (s_tdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign non_empty = (count != '0);
    assign is_last   = !non_empty || ((CW'(idx_reg) + CW'(1)) == count);

    // sequencer: accept, set up first read, then list entries
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (in_fire)
                begin
                    status_next = upd.status;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                idx_next   = '0;
                state_next = ST_LIST;
            end
            ST_LIST:
            begin
                if (out_fire)
                begin
                    if (is_last)
                    begin
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // read address: entry idx_next counted from the head, wrapped
    assign rd_sum  = (AW+1)'(head) + (AW+1)'(idx_next);
    assign rd_addr = (rd_sum >= CAP_EXT) ? AW'(rd_sum - CAP_EXT) : AW'(rd_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            status_reg <= STATUS_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
        end
    end

    // output word comes straight from the RAM read register, or is zero when the store is empty
    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = (state_reg == ST_LIST);
    assign m_tdata    = non_empty ? rd_data : '0;
    assign m_tuser    = {non_empty, status_reg};
    assign m_tlast    = is_last;

    // no input is taken while a listing is in flight
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input accepted during listing");

    // an empty listing is a single word
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[2]) |-> (m_tlast && m_tdata == '0))
        else $error("empty listing not a single zero word");

    // first result never appears in the cycle right after accept
    a_prep_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !m_tvalid)
        else $error("result shown before RAM read completed");

    // count never exceeds capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(CAPACITY))
        else $error("fill count above capacity");

endmodule

### rtl/core/fad_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fad_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/fad_index.sv
// Head pointer and fill count of the circular entry store; decodes each
// operation into a memory write and a status. Depends on fad_pkg.
module fad_index
    import fad_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        apply,
    input  fad_kind_t                   kind,
    output fad_upd_t                    upd,
    output logic [$clog2(CAPACITY)-1:0] wr_addr,
    output logic [$clog2(CAPACITY)-1:0] head,
    output logic [$clog2(CAPACITY+1)-1:0] count
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [AW:0] CAP_EXT = (AW+1)'(CAPACITY);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW:0]   tail_sum;
    logic [AW-1:0] tail_slot;
    logic [AW-1:0] head_dec, head_inc;
    logic          full, empty;

    assign full  = (count_reg == CW'(CAPACITY));
    assign empty = (count_reg == '0);

    // slot just past the back entry, wrapped
    assign tail_sum  = (AW+1)'(head_reg) + (AW+1)'(count_reg);
    assign tail_slot = (tail_sum >= CAP_EXT) ? AW'(tail_sum - CAP_EXT) : AW'(tail_sum);

    assign head_dec = (head_reg == '0) ? LAST_SLOT : head_reg - AW'(1);
    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);

    // operation decode
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        upd.en     = 1'b0;
        upd.status = STATUS_DONE;
        wr_addr    = tail_slot;
        case (kind)
            KIND_PUSH_BACK:
            begin
                if (full)
                begin
                    upd.status = STATUS_OVERFLOW;
                end
                else
                begin
                    upd.en     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            KIND_PUSH_FRONT:
            begin
                wr_addr = head_dec;
                if (full)
                begin
                    upd.status = STATUS_OVERFLOW;
                end
                else
                begin
                    upd.en     = 1'b1;
                    head_next  = head_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            KIND_POP_BACK:
            begin
                if (empty)
                begin
                    upd.status = STATUS_UNDERFLOW;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            KIND_POP_FRONT:
            begin
                if (empty)
                begin
                    upd.status = STATUS_UNDERFLOW;
                end
                else
                begin
                    head_next  = head_inc;
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                upd.status = STATUS_DONE;
            end
        endcase
    end

    // pointer and count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (apply)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    assign head  = head_reg;
    assign count = count_reg;

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for fixed_array_deque_shift: a directed table, then biased random
// operations that fill and drain the store, checked word by word against a deque predictor.
// Depends on fad_pkg and the fixed_array_deque_shift RTL.
module tb_top
    import fad_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int DIR_ROWS    = 26;
    localparam int PHASE_ITEMS = 148;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 20;

    // one listed word: status, entry value, entry valid, last
    typedef struct packed {
        fad_status_t status;
        logic [31:0] value;
        logic        valid;
        logic        last;
    } listing_word_t;

    // directed row; typed rows carry their single expected word
    typedef struct packed {
        fad_kind_t     kind;
        logic [31:0]   value;
        logic          typed;
        listing_word_t word;
    } stim_row_t;

    localparam listing_word_t UNTYPED = '0;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = KIND_PUSH_BACK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // predictor state
    logic [31:0]   deque_slots [DEPTH];
    int            deque_count = 0;
    listing_word_t op_listing [$];
    listing_word_t pending_words [$];

    // run bookkeeping
    int tx_idle_pct   = 37;
    int rx_idle_pct   = 45;
    int error_count   = 0;
    int cycle_count   = 0;
    int n_items       = 0;
    int n_words       = 0;
    int n_overflow    = 0;
    int n_underflow   = 0;
    int n_full_hits   = 0;
    int n_empty_lists = 0;
    bit filling       = 1'b1;

    stim_row_t directed_rows [DIR_ROWS] = '{
        // deletes on the empty store, then a single entry in and out at each end
        '{KIND_POP_BACK,   32'h0000_0000, 1'b1, '{STATUS_UNDERFLOW, 32'h0, 1'b0, 1'b1}},
        '{KIND_POP_FRONT,  32'h0000_0000, 1'b1, '{STATUS_UNDERFLOW, 32'h0, 1'b0, 1'b1}},
        '{KIND_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, '{STATUS_DONE, 32'h7FFF_FFFF, 1'b1, 1'b1}},
        '{KIND_POP_FRONT,  32'h0000_0000, 1'b1, '{STATUS_DONE, 32'h0, 1'b0, 1'b1}},
        '{KIND_PUSH_FRONT, 32'h8000_0000, 1'b1, '{STATUS_DONE, 32'h8000_0000, 1'b1, 1'b1}},
        '{KIND_POP_BACK,   32'hFFFF_FFFF, 1'b1, '{STATUS_DONE, 32'h0, 1'b0, 1'b1}},
        // fill to capacity from both ends
        '{KIND_PUSH_BACK,  32'hFFFF_FFFF, 1'b0, UNTYPED},
        '{KIND_PUSH_FRONT, 32'h0000_0000, 1'b0, UNTYPED},
        '{KIND_PUSH_BACK,  32'h0000_0001, 1'b0, UNTYPED},
        '{KIND_PUSH_FRONT, 32'h8000_0000, 1'b0, UNTYPED},
        '{KIND_PUSH_BACK,  32'h7FFF_FFFF, 1'b0, UNTYPED},
        '{KIND_PUSH_FRONT, 32'h5555_5555, 1'b0, UNTYPED},
        '{KIND_PUSH_BACK,  32'hAAAA_AAAA, 1'b0, UNTYPED},
        '{KIND_PUSH_FRONT, 32'h1234_5678, 1'b0, UNTYPED},
        '{KIND_PUSH_BACK,  32'h8765_4321, 1'b0, UNTYPED},
        '{KIND_PUSH_FRONT, 32'h0F0F_0F0F, 1'b0, UNTYPED},
        '{KIND_PUSH_BACK,  32'hF0F0_F0F0, 1'b0, UNTYPED},
        '{KIND_PUSH_FRONT, 32'h0000_0002, 1'b0, UNTYPED},
        '{KIND_PUSH_BACK,  32'hFFFF_FFFE, 1'b0, UNTYPED},
        '{KIND_PUSH_FRONT, 32'h7FFF_FFFE, 1'b0, UNTYPED},
        '{KIND_PUSH_BACK,  32'h8000_0001, 1'b0, UNTYPED},
        '{KIND_PUSH_FRONT, 32'hDEAD_BEEF, 1'b0, UNTYPED},
        // overflow at both ends, then full-length shifts out
        '{KIND_PUSH_BACK,  32'h0000_CAFE, 1'b0, UNTYPED},
        '{KIND_PUSH_FRONT, 32'h0000_BEEF, 1'b0, UNTYPED},
        '{KIND_POP_FRONT,  32'h0000_0000, 1'b0, UNTYPED},
        '{KIND_POP_BACK,   32'h0000_0000, 1'b0, UNTYPED}
    };

    fixed_array_deque_shift #(
        .CAPACITY (DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // deque predictor: applies one operation and builds its listing
    function automatic void predict_listing(fad_kind_t kind, logic [31:0] value);
        fad_status_t st;
        int          i;
        st = STATUS_DONE;
        op_listing.delete();
        case (kind)
            KIND_PUSH_BACK:
            begin
                if (deque_count < DEPTH)
                begin
                    deque_slots[deque_count] = value;
                    deque_count++;
                end
                else
                    st = STATUS_OVERFLOW;
            end
            KIND_PUSH_FRONT:
            begin
                if (deque_count < DEPTH)
                begin
                    for (i = deque_count; i > 0; i--)
                        deque_slots[i] = deque_slots[i - 1];
                    deque_slots[0] = value;
                    deque_count++;
                end
                else
                    st = STATUS_OVERFLOW;
            end
            KIND_POP_BACK:
            begin
                if (deque_count > 0)
                    deque_count--;
                else
                    st = STATUS_UNDERFLOW;
            end
            default:
            begin
                if (deque_count > 0)
                begin
                    for (i = 0; i + 1 < deque_count; i++)
                        deque_slots[i] = deque_slots[i + 1];
                    deque_count--;
                end
                else
                    st = STATUS_UNDERFLOW;
            end
        endcase

        // bookkeeping for the summary
        if (st == STATUS_OVERFLOW)
            n_overflow++;
        if (st == STATUS_UNDERFLOW)
            n_underflow++;
        if (deque_count == DEPTH)
            n_full_hits++;

        if (deque_count == 0)
        begin
            n_empty_lists++;
            op_listing.push_back('{st, 32'h0, 1'b0, 1'b1});
        end
        else
        begin
            for (i = 0; i < deque_count; i++)
                op_listing.push_back('{st, deque_slots[i], 1'b1, (i + 1 == deque_count)});
        end
    endfunction

    // present one word, hold it until accepted, then record its listing
    task automatic send_word(fad_kind_t kind, logic [31:0] value, logic typed,
                             listing_word_t word);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        n_items++;
        predict_listing(kind, value);
        if (typed)
            pending_words.push_back(word);
        else
            foreach (op_listing[i])
                pending_words.push_back(op_listing[i]);
    endtask

    // hold the input off until every listed word has come back
    task automatic drain_listings();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0);
    endtask

    // random operations, biased to sweep the store between empty and full
    task automatic send_random(int n);
        fad_kind_t   kind;
        logic [31:0] value;
        int          r;
        bit          push;
        for (int k = 0; k < n; k++)
        begin
            if (deque_count == DEPTH)
                filling = 1'b0;
            else if (deque_count == 0)
                filling = 1'b1;
            r = $urandom_range(99);
            if (r < 10)
                kind = fad_kind_t'($urandom_range(3));
            else
            begin
                push = (r < 75) ? filling : !filling;
                if (push)
                    kind = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
                else
                    kind = $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
            end
            case ($urandom_range(15))
                0:       value = 32'h8000_0000;
                1:       value = 32'h7FFF_FFFF;
                2:       value = 32'hFFFF_FFFF;
                3:       value = 32'h0000_0000;
                default: value = $urandom;
            endcase
            send_word(kind, value, 1'b0, UNTYPED);
        end
    endtask

    // receiver stalls
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rx_idle_pct);

    // compare every accepted result word with the oldest expectation
    always @(posedge clk)
    begin : check_words
        listing_word_t exp_w;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_words++;
            if (pending_words.size() == 0)
            begin
                $error("unexpected result word: value %h tuser %b last %b",
                       m_tdata, m_tuser, m_tlast);
                error_count++;
            end
            else
            begin
                exp_w = pending_words.pop_front();
                if (m_tuser[1:0] !== exp_w.status)
                begin
                    $error("status: expected %0d, got %0d", exp_w.status, m_tuser[1:0]);
                    error_count++;
                end
                if (m_tdata !== exp_w.value)
                begin
                    $error("entry_value: expected %h, got %h", exp_w.value, m_tdata);
                    error_count++;
                end
                if (m_tuser[2] !== exp_w.valid)
                begin
                    $error("entry_valid: expected %b, got %b", exp_w.valid, m_tuser[2]);
                    error_count++;
                end
                if (m_tlast !== exp_w.last)
                begin
                    $error("last: expected %b, got %b", exp_w.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_words.size());
            $display("** fixed_array_deque_shift: FAILED **");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
            send_word(directed_rows[r].kind, directed_rows[r].value,
                      directed_rows[r].typed, directed_rows[r].word);
        drain_listings();

        // random: receiver idles more than sender, then swapped, then no idling
        send_random(PHASE_ITEMS);
        drain_listings();
        tx_idle_pct = 45;
        rx_idle_pct = 37;
        send_random(PHASE_ITEMS);
        drain_listings();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(PHASE_ITEMS);
        drain_listings();

        // let any stray words show up
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d operations, %0d result words, %0d empty listings",
                 n_items, n_words, n_empty_lists);
        $display("store reached full %0d times; %0d overflows, %0d underflows, %0d errors",
                 n_full_hits, n_overflow, n_underflow, error_count);
        if (error_count == 0)
            $display("** fixed_array_deque_shift: PASSED **");
        else
            $display("** fixed_array_deque_shift: FAILED **");
        $finish;
    end

endmodule
